FILE: rtl/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner package
// Shared types, codes and constants for the scanner controller and datapath.
// ----------------------------------------------------------------------------
package lmbs_pkg;

   // Default geometry of the panel.
   localparam int COLUMNS_DEF   = 128;
   localparam int ROW_PAIRS_DEF = 16;
   localparam int PLANES_DEF    = 4;

   // Widest column pair index and frame store address over the legal geometry.
   localparam int PAIR_W_MAX = 7;
   localparam int ADDR_W_MAX = 13;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL      = 2'd2;

   // Request actions.
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_COMMIT = 2'd1;
   localparam logic [1:0] ACT_SCAN   = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] pixel_row;
      logic [6:0] pixel_col;
      logic [3:0] pixel_planes;
   } req_type;

   typedef struct packed {
      logic [5:0] column_pair;
      logic [2:0] top_even_rgb;
      logic [2:0] bottom_even_rgb;
      logic [2:0] top_odd_rgb;
      logic [2:0] bottom_odd_rgb;
      logic       blank_even;
      logic       blank_odd;
      logic [3:0] row_address;
      logic [1:0] plane_index;
      logic [5:0] hold_time;
      logic       swap_pending;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                  clr_we;
      logic [ADDR_W_MAX-1:0] clr_addr;
      logic                  pix_write;
      logic                  commit;
      logic                  rd_en;
      logic [PAIR_W_MAX-1:0] rd_pair;
      logic                  load;
      logic [PAIR_W_MAX-1:0] load_pair;
      logic                  load_last;
      logic                  scan_done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } stat_type;

   // Panel hold time in microseconds for each bit plane.
   function automatic logic [5:0] hold_us(input logic [2:0] plane);
      logic [5:0] t;
      unique case (plane)
         3'd0:    t = 6'd1;
         3'd1:    t = 6'd2;
         3'd2:    t = 6'd30;
         default: t = 6'd45;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/lmbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmbs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lmbs_ctrl.sv
// ----------------------------------------------------------------------------
// LED matrix scanner controller
// Clearing pass, request acceptance and column pair sequencing of a scan.
// ----------------------------------------------------------------------------
module lmbs_ctrl #(
   parameter int COLUMNS   = 128,
   parameter int ROW_PAIRS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  lmbs_pkg::req_type  req_payload,
   output logic               req_stall,
   input  lmbs_pkg::stat_type stat,
   output lmbs_pkg::cmd_type  cmd
);
   import lmbs_pkg::*;

   localparam int PAIRS = COLUMNS / 2;
   localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int RW    = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
   localparam int AW    = 1 + RW + PW;
   localparam int IW    = $clog2(PAIRS + 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic [PW-1:0] pend_pair_ff, pend_pair_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          accept;
   logic          move;
   logic          issue;
   logic          done;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // A fetched pair moves to the output register when that register is free.
   assign move  = rd_pend_ff && stat.out_free;
   assign issue = (state_ff == ST_SCAN) && (issue_ff < IW'(PAIRS)) && (!rd_pend_ff || move);
   assign done  = move && (pend_pair_ff == PW'(PAIRS - 1));

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      issue_in     = issue ? issue_ff + 1'b1 : issue_ff;
      rd_pend_in   = issue ? 1'b1 : (move ? 1'b0 : rd_pend_ff);
      pend_pair_in = issue ? issue_ff[PW-1:0] : pend_pair_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_payload.action == ACT_SCAN)) begin
               state_in = ST_SCAN;
               issue_in = '0;
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.clr_we    = (state_ff == ST_CLEAR);
      cmd.clr_addr  = ADDR_W_MAX'(clr_addr_ff);
      cmd.pix_write = accept && (req_payload.action == ACT_WRITE);
      cmd.commit    = accept && (req_payload.action == ACT_COMMIT);
      cmd.rd_en     = issue;
      cmd.rd_pair   = PAIR_W_MAX'(issue_ff[PW-1:0]);
      cmd.load      = move;
      cmd.load_pair = PAIR_W_MAX'(pend_pair_ff);
      cmd.load_last = (pend_pair_ff == PW'(PAIRS - 1));
      cmd.scan_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         issue_ff    <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         issue_ff    <= issue_in;
         rd_pend_ff  <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pair_ff <= pend_pair_in;
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == ST_IDLE))
      else $error("scan end did not return the controller to idle");

   a_no_pend_outside_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> !rd_pend_ff)
      else $error("fetched pair left pending outside a scan");

   a_scan_starts_clean: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (issue_ff == '0)) |-> !rd_pend_ff)
      else $error("scan started with a stale fetched pair");

endmodule

FILE: rtl/lmbs_dp.sv
// ----------------------------------------------------------------------------
// LED matrix scanner datapath
// Frame store banks, display state, configuration and result register.
// ----------------------------------------------------------------------------
module lmbs_dp #(
   parameter int COLUMNS   = 128,
   parameter int ROW_PAIRS = 16,
   parameter int PLANES    = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lmbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmbs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  lmbs_pkg::req_type                   req_payload,
   input  lmbs_pkg::cmd_type                   cmd,
   output lmbs_pkg::stat_type                  stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lmbs_pkg::rsp_type                   rsp_payload
);
   import lmbs_pkg::*;

   localparam int PAIRS = COLUMNS / 2;
   localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int RW    = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
   localparam int PLW   = (PLANES > 1) ? $clog2(PLANES) : 1;
   localparam int AW    = 1 + RW + PW;
   localparam int DEPTH = 2 ** AW;

   localparam int BANK_TOP_EVEN = 0;
   localparam int BANK_TOP_ODD  = 1;
   localparam int BANK_BOT_EVEN = 2;
   localparam int BANK_BOT_ODD  = 3;

   logic [5:0]     bright_ff;
   logic [2:0]     colour_ff;
   logic           panel_ff;
   logic           active_ff, active_in;
   logic           in_use_ff, in_use_in;
   logic [RW-1:0]  scan_row_ff, scan_row_in;
   logic [PLW-1:0] plane_ff, plane_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [6:0]    row_w;
   logic [8:0]    col_w;
   logic          in_range;
   logic          is_bottom;
   logic [6:0]    row_off;
   logic [1:0]    wr_bank;
   logic [AW-1:0] wr_addr;
   logic [3:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [3:0]    bank_we;
   logic [3:0]    bank_rd [4];

   logic [3:0] chan_m;
   logic [2:0] chan;
   logic [2:0] plane3;
   logic [7:0] pair_ext;
   logic [8:0] col_even;
   logic [8:0] col_odd;
   logic [8:0] bright_ext;
   logic [7:0] row_ext;

   function automatic logic [2:0] pix_rgb(input logic [3:0] pix, input logic [2:0] plane,
                                          input logic inv, input logic [2:0] en);
      logic bit_v;
      bit_v = (plane < 3'd4) ? pix[plane[1:0]] : 1'b0;
      bit_v = bit_v ^ inv;
      return bit_v ? en : 3'b000;
   endfunction

   assign csr_ready = 1'b1;

   // Pixel write decode: upper or lower half, even or odd column.
   assign row_w     = {2'b00, req_payload.pixel_row};
   assign col_w     = {2'b00, req_payload.pixel_col};
   assign in_range  = (row_w < 7'(2 * ROW_PAIRS)) && (col_w < 9'(2 * PAIRS));
   assign is_bottom = (row_w >= 7'(ROW_PAIRS));
   assign row_off   = is_bottom ? (row_w - 7'(ROW_PAIRS)) : row_w;
   assign wr_bank   = {is_bottom, req_payload.pixel_col[0]};

   assign wr_addr = cmd.clr_we ? cmd.clr_addr[AW-1:0]
                               : {~active_ff, row_off[RW-1:0],
                                  PW'(req_payload.pixel_col >> 1)};
   assign wr_data = cmd.clr_we ? 4'd0 : req_payload.pixel_planes;
   assign rd_addr = {in_use_ff, scan_row_ff, cmd.rd_pair[PW-1:0]};

   for (genvar b = 0; b < 4; b++) begin : g_bank
      assign bank_we[b] = cmd.clr_we || (cmd.pix_write && in_range && (wr_bank == 2'(b)));

      lmbs_ram #(
         .WIDTH (4),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .we      (bank_we[b]),
         .waddr   (wr_addr),
         .wdata   (wr_data),
         .re      (cmd.rd_en),
         .raddr   (rd_addr),
         .rd_data (bank_rd[b])
      );
   end

   // Result formatting for the pair that leaves the frame store.
   assign chan_m     = {1'b0, colour_ff} + 4'd1;
   assign chan       = chan_m[2:0];
   assign plane3     = 3'(plane_ff);
   assign pair_ext   = 8'(cmd.load_pair);
   assign col_even   = {pair_ext, 1'b0};
   assign col_odd    = col_even | 9'd1;
   assign bright_ext = {3'b000, bright_ff};
   assign row_ext    = 8'(scan_row_ff);

   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_valid_in           = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         rsp_valid_in           = 1'b1;
         rsp_in.column_pair     = pair_ext[5:0];
         rsp_in.top_even_rgb    = pix_rgb(bank_rd[BANK_TOP_EVEN], plane3, panel_ff, chan);
         rsp_in.bottom_even_rgb = pix_rgb(bank_rd[BANK_BOT_EVEN], plane3, panel_ff, chan);
         rsp_in.top_odd_rgb     = pix_rgb(bank_rd[BANK_TOP_ODD], plane3, panel_ff, chan);
         rsp_in.bottom_odd_rgb  = pix_rgb(bank_rd[BANK_BOT_ODD], plane3, panel_ff, chan);
         rsp_in.blank_even      = (col_even >= bright_ext);
         rsp_in.blank_odd       = (col_odd >= bright_ext);
         rsp_in.row_address     = row_ext[3:0];
         rsp_in.plane_index     = plane3[1:0];
         rsp_in.hold_time       = cmd.load_last ? hold_us(plane3) : 6'd0;
         rsp_in.swap_pending    = (active_ff != in_use_ff);
         rsp_in.last            = cmd.load_last;
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

   // Display state: buffer swap, row and plane advance.
   always_comb begin
      active_in   = cmd.commit ? ~active_ff : active_ff;
      in_use_in   = in_use_ff;
      scan_row_in = scan_row_ff;
      plane_in    = plane_ff;
      if (cmd.scan_done) begin
         if (scan_row_ff == RW'(ROW_PAIRS - 1)) begin
            scan_row_in = '0;
            if (plane_ff == PLW'(PLANES - 1)) begin
               plane_in  = '0;
               in_use_in = active_ff;
            end else begin
               plane_in = plane_ff + 1'b1;
            end
         end else begin
            scan_row_in = scan_row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= '0;
         colour_ff    <= '0;
         panel_ff     <= 1'b0;
         active_ff    <= 1'b0;
         in_use_ff    <= 1'b0;
         scan_row_ff  <= '0;
         plane_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         in_use_ff    <= in_use_in;
         scan_row_ff  <= scan_row_in;
         plane_ff     <= plane_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BRIGHTNESS: bright_ff <= csr_wdata;
               CSR_COLOUR:     colour_ff <= csr_wdata[2:0];
               CSR_PANEL:      panel_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_in_use_only_at_pass_end: assert property (@(posedge clock) disable iff (reset)
      !cmd.scan_done |=> $stable(in_use_ff))
      else $error("buffer in use changed outside the end of a scan");

   a_row_only_at_scan_end: assert property (@(posedge clock) disable iff (reset)
      !cmd.scan_done |=> ($stable(scan_row_ff) && $stable(plane_ff)))
      else $error("row or plane advanced outside the end of a scan");

   a_hold_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> (rsp_payload.hold_time == 6'd0))
      else $error("hold time reported on a result that is not the last");

endmodule

FILE: rtl/led_matrix_bitplane_scanner_top.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner, top level
// Double-buffered dot-matrix frame store with bit-plane row pair scanning.
// ----------------------------------------------------------------------------
// Pixel write and commit requests complete on acceptance.
// A scan request yields COLUMNS/2 results, which follow one per cycle while
// results do not stall, paced by the frame store read port; no further
// request is accepted until the last result enters the result register.
// After reset, a clearing pass zeroes all 2^(1 + log2(ROW_PAIRS) +
// log2(COLUMNS/2)) addresses (2048) of each frame store bank.
module led_matrix_bitplane_scanner_top #(
   parameter int COLUMNS   = lmbs_pkg::COLUMNS_DEF,
   parameter int ROW_PAIRS = lmbs_pkg::ROW_PAIRS_DEF,
   parameter int PLANES    = lmbs_pkg::PLANES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lmbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lmbs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lmbs_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lmbs_pkg::rsp_type                rsp_payload
);
   import lmbs_pkg::*;

   // The controller owns sequencing: it runs the clearing pass after reset,
   // accepts requests only while idle, and during a scan fetches one column
   // pair per cycle from the four frame store banks (upper and lower row,
   // even and odd column). A fetched pair waits in the bank read registers
   // until the result register is free, so a stalled consumer simply holds
   // the scan without losing a pair.
   cmd_type  cmd;
   stat_type stat;

   lmbs_ctrl #(
      .COLUMNS   (COLUMNS),
      .ROW_PAIRS (ROW_PAIRS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   // The datapath holds the frame store, the buffer and scan position state,
   // the configuration registers and the result register. The buffer in use
   // follows the committed buffer only after the last plane of the last row
   // pair has been shown, so a frame is never torn mid-pass.
   lmbs_dp #(
      .COLUMNS   (COLUMNS),
      .ROW_PAIRS (ROW_PAIRS),
      .PLANES    (PLANES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner testbench
// Drives pixel write, commit and scan requests into the scanner, predicts
// every column pair result from a private copy of both frame buffers and of
// the scan position, and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import lmbs_pkg::*;

   // Geometry of the instance under test (package defaults).
   localparam int COLS      = COLUMNS_DEF;
   localparam int ROW_PAIRS = ROW_PAIRS_DEF;
   localparam int PLANES    = PLANES_DEF;
   localparam int ROWS      = 2 * ROW_PAIRS;
   localparam int PAIRS     = COLS / 2;

   // Codes with no meaning to the block, used to check that they are ignored.
   localparam logic [1:0]             ACT_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 2'd3;

   // The watchdog gives up after this many cycles in which no handshake of any
   // channel completes. The longest quiet stretch of a correct run is the
   // frame store clearing pass after reset.
   localparam int IDLE_LIMIT = 10000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;

   // Percentages of cycles in which the request side holds back and in which
   // the result side stalls. They change between phases of the run.
   int send_idle_pct = 20;
   int stall_pct     = 65;

   // -------------------------------------------------------------------------
   // Scoreboard: a private model of the scanner plus the queue of results
   // that it still owes.
   // -------------------------------------------------------------------------
   class scanner_scoreboard;
      bit [3:0] frame [2][ROWS][COLS];
      bit       active_buf;
      bit       shown_buf;
      int       row_ptr;
      int       plane_ptr;
      bit [5:0] bright;
      bit [2:0] colour;
      bit       panel;
      rsp_type  expected_q[$];
      int       errors;

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BRIGHTNESS: bright = data;
            CSR_COLOUR:     colour = data[2:0];
            CSR_PANEL:      panel  = data[0];
            default:        ;
         endcase
      endfunction

      // Channel bits of one pixel in the current plane.
      function bit [2:0] plane_rgb(bit [3:0] pix, bit [2:0] chan);
         bit lit;
         lit = pix[plane_ptr] ^ panel;
         return lit ? chan : 3'd0;
      endfunction

      function void note_request(req_type r);
         rsp_type  e;
         bit [3:0] mask;
         bit [5:0] hold;
         int       ce, co;
         case (r.action)
            ACT_WRITE: begin
               if (r.pixel_row < ROWS && r.pixel_col < COLS)
                  frame[!active_buf][r.pixel_row][r.pixel_col] = r.pixel_planes;
            end
            ACT_COMMIT: active_buf = !active_buf;
            ACT_SCAN: begin
               // A colour select of seven wraps to eight, which turns every
               // channel off.
               mask = {1'b0, colour} + 4'd1;
               case (plane_ptr)
                  0:       hold = 6'd1;
                  1:       hold = 6'd2;
                  2:       hold = 6'd30;
                  default: hold = 6'd45;
               endcase
               for (int k = 0; k < PAIRS; k++) begin
                  ce = 2 * k;
                  co = 2 * k + 1;
                  e.column_pair     = 6'(k);
                  e.top_even_rgb    = plane_rgb(frame[shown_buf][row_ptr][ce], mask[2:0]);
                  e.bottom_even_rgb = plane_rgb(frame[shown_buf][row_ptr + ROW_PAIRS][ce],
                                                mask[2:0]);
                  e.top_odd_rgb     = plane_rgb(frame[shown_buf][row_ptr][co], mask[2:0]);
                  e.bottom_odd_rgb  = plane_rgb(frame[shown_buf][row_ptr + ROW_PAIRS][co],
                                                mask[2:0]);
                  e.blank_even      = (ce >= bright);
                  e.blank_odd       = (co >= bright);
                  e.row_address     = 4'(row_ptr);
                  e.plane_index     = 2'(plane_ptr);
                  e.last            = (k == PAIRS - 1);
                  e.hold_time       = e.last ? hold : 6'd0;
                  e.swap_pending    = (active_buf != shown_buf);
                  expected_q.push_back(e);
               end
               // The committed buffer is taken up only after a whole pass.
               row_ptr++;
               if (row_ptr >= ROW_PAIRS) begin
                  row_ptr = 0;
                  plane_ptr++;
                  if (plane_ptr >= PLANES) begin
                     plane_ptr = 0;
                     shown_buf = active_buf;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [5:0] want, logic [5:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("column_pair",     e.column_pair,     got.column_pair);
         compare_field("top_even_rgb",    e.top_even_rgb,    got.top_even_rgb);
         compare_field("bottom_even_rgb", e.bottom_even_rgb, got.bottom_even_rgb);
         compare_field("top_odd_rgb",     e.top_odd_rgb,     got.top_odd_rgb);
         compare_field("bottom_odd_rgb",  e.bottom_odd_rgb,  got.bottom_odd_rgb);
         compare_field("blank_even",      e.blank_even,      got.blank_even);
         compare_field("blank_odd",       e.blank_odd,       got.blank_odd);
         compare_field("row_address",     e.row_address,     got.row_address);
         compare_field("plane_index",     e.plane_index,     got.plane_index);
         compare_field("hold_time",       e.hold_time,       got.hold_time);
         compare_field("swap_pending",    e.swap_pending,    got.swap_pending);
         compare_field("last",            e.last,            got.last);
      endfunction
   endclass

   scanner_scoreboard sb;

   led_matrix_bitplane_scanner_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side. The handshake is judged on the values seen just before the
   // edge, then a fresh stall decision is driven for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_payload);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog: a hang anywhere shows up as a long run of cycles in which no
   // channel completes a handshake.
   initial begin : watchdog
      int quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   function automatic req_type make_req(logic [1:0] action, int row, int col, int planes);
      req_type r;
      r.action       = action;
      r.pixel_row    = 5'(row);
      r.pixel_col    = 7'(col);
      r.pixel_planes = 4'(planes);
      return r;
   endfunction

   // Offers one request and holds it until the scanner takes it. The valid
   // stays high when the next request follows at once, so it is never
   // lowered and raised in the same step.
   task automatic send_request(input req_type r);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One register write. The valid drops for a cycle after each write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Holds off new requests until every owed result has arrived, then idles
   // before returning so that a trailing write has surely landed.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Random traffic. Scans dominate so that whole passes complete and the
   // committed buffer comes into use; half the pixel writes are aimed at the
   // row pairs about to be scanned so that written content shows up quickly.
   // Halfway through, the sender pauses until all results are in.
   task automatic random_phase(input int count);
      int      pick;
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            drain_results();
         pick           = $urandom_range(99);
         r.pixel_row    = 5'($urandom);
         r.pixel_col    = 7'($urandom);
         r.pixel_planes = 4'($urandom);
         if (pick < 40) begin
            r.action = ACT_WRITE;
            if ($urandom_range(1))
               r.pixel_row = 5'((sb.row_ptr + $urandom_range(2)) % ROW_PAIRS
                                + ($urandom_range(1) ? ROW_PAIRS : 0));
         end else if (pick < 45) begin
            r.action = ACT_COMMIT;
         end else if (pick < 49) begin
            r.action = ACT_UNUSED;
         end else begin
            r.action = ACT_SCAN;
         end
         send_request(r);
      end
   endtask

   initial begin : stimulus
      int b, c, t;
      sb = new();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A brightness of five puts the blanking edge inside a
      // column pair; all three channels are enabled.
      write_register(CSR_BRIGHTNESS, 6'd5);
      write_register(CSR_COLOUR, 6'd6);
      write_register(CSR_PANEL, 6'd0);

      // Nothing written yet: a scan of the cleared store.
      send_request(make_req(ACT_SCAN, 0, 0, 0));
      // Corner pixels and extreme plane values, all into the hidden buffer.
      send_request(make_req(ACT_WRITE, 0, 0, 15));
      send_request(make_req(ACT_WRITE, 16, 1, 1));
      send_request(make_req(ACT_WRITE, 31, 127, 15));
      send_request(make_req(ACT_WRITE, 15, 126, 8));
      send_request(make_req(ACT_WRITE, 0, 127, 0));
      // An unknown action must leave everything alone.
      send_request(make_req(ACT_UNUSED, 31, 127, 15));
      // Commit: the swap stays pending until the pass ends.
      send_request(make_req(ACT_COMMIT, 0, 0, 0));
      send_request(make_req(ACT_SCAN, 0, 0, 0));
      // Writes while a swap is pending land in the buffer still on display,
      // so the scan of row pair two shows them.
      send_request(make_req(ACT_WRITE, 2, 64, 15));
      send_request(make_req(ACT_WRITE, 18, 65, 15));
      send_request(make_req(ACT_SCAN, 0, 0, 0));
      // Two commits, with a scan between, cancel and then restore the pending swap.
      send_request(make_req(ACT_COMMIT, 0, 0, 0));
      send_request(make_req(ACT_SCAN, 0, 0, 0));
      send_request(make_req(ACT_COMMIT, 0, 0, 0));
      send_request(make_req(ACT_SCAN, 0, 0, 0));

      // Random phases, each with its own register setting. The idling mode
      // moves from a slow receiver to a slow sender to no idling at all.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 65;
            stall_pct     = 20;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         drain_results();
         case (phase)
            0: begin b = 63; c = 7; t = 1; end
            1: begin b = 0;  c = 0; t = 0; end
            2: begin b = $urandom_range(63); c = $urandom_range(7); t = 1; end
            3: begin b = 32; c = 3; t = 0; end
            4: begin b = $urandom_range(63); c = $urandom_range(7); t = $urandom_range(1); end
            default: begin b = 1; c = 6; t = 1; end
         endcase
         // Writes to an unused register index must be ignored.
         if (phase == 3)
            write_register(CSR_SPARE, 6'($urandom));
         write_register(CSR_BRIGHTNESS, 6'(b));
         // Upper data bits are random; the block keeps only the low bits.
         write_register(CSR_COLOUR, {3'($urandom), 3'(c)});
         write_register(CSR_PANEL, {5'($urandom), 1'(t)});
         random_phase(36);
      end

      drain_results();
      repeat (70) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
rtl/lmbs_pkg.sv
rtl/lmbs_ram.sv
rtl/lmbs_ctrl.sv
rtl/lmbs_dp.sv
rtl/led_matrix_bitplane_scanner_top.sv
dv/testbench.sv
